/* rtl/aru_pkg.sv */
// AES round unit package: field widths, stage payload types, S-box tables
// and GF(2^8) helpers. Used by the interfaces and every RTL module.
package aru_pkg;

  localparam int WORD_W = 64;
  localparam int MODE_W = 2;

  typedef logic [15:0][7:0] aru_blk_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENC      = 2'd0,
    MODE_ENC_LAST = 2'd1,
    MODE_DEC      = 2'd2,
    MODE_DEC_LAST = 2'd3
  } aru_mode_t;

  typedef struct packed {
    aru_mode_t mode;
    aru_blk_t  state;
    aru_blk_t  key;
  } aru_req_t;

  typedef struct packed {
    logic     last;
    logic     dec;
    aru_blk_t data;
    aru_blk_t key;
  } aru_sub_t;

  typedef struct packed {
    aru_blk_t data;
    aru_blk_t key;
  } aru_mix_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] DEC_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [7:0] GF_POLY = 8'h1b;

  function automatic logic [7:0] gf_xt(input logic [7:0] a);
    gf_xt = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
    logic [3:0][7:0] a;
    logic [3:0][7:0] x2;
    logic [3:0][7:0] x4;
    logic [3:0][7:0] x8;
    logic [3:0][7:0] m1;
    logic [3:0][7:0] m2;
    logic [3:0][7:0] m3;
    logic [3:0][7:0] m0;
    logic [3:0][7:0] o;
    a = col;
    for (int j = 0; j < 4; j++) begin
      x2[j] = gf_xt(a[j]);
      x4[j] = gf_xt(x2[j]);
      x8[j] = gf_xt(x4[j]);
      if (inv) begin
        m0[j] = x8[j] ^ x4[j] ^ x2[j];
        m1[j] = x8[j] ^ x2[j] ^ a[j];
        m2[j] = x8[j] ^ x4[j] ^ a[j];
        m3[j] = x8[j] ^ a[j];
      end else begin
        m0[j] = x2[j];
        m1[j] = x2[j] ^ a[j];
        m2[j] = a[j];
        m3[j] = a[j];
      end
    end
    for (int r = 0; r < 4; r++) begin
      o[r] = m0[r] ^ m1[(r + 1) % 4] ^ m2[(r + 2) % 4] ^ m3[(r + 3) % 4];
    end
    mix_col = o;
  endfunction

endpackage

/* rtl/aru_if.sv */
// Item channel interfaces of the AES round unit: request and result.
// Depends on aru_pkg for field widths.
interface aru_in_if import aru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] state_lo;
  logic [WORD_W-1:0] state_hi;
  logic [WORD_W-1:0] key_lo;
  logic [WORD_W-1:0] key_hi;

  modport source(output valid, mode, state_lo, state_hi, key_lo, key_hi, input ready);
  modport sink(input valid, mode, state_lo, state_hi, key_lo, key_hi, output ready);
endinterface

interface aru_out_if import aru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_lo;
  logic [WORD_W-1:0] result_hi;

  modport source(output valid, result_lo, result_hi, input ready);
  modport sink(input valid, result_lo, result_hi, output ready);
endinterface

/* rtl/aes_round_unit.sv */
// AES round unit: one encrypt, encrypt-last, decrypt or decrypt-last round per item.
// Pipeline from accept to result valid: S-box stage, column-mix stage, then
// round-key add into the output register. Throughput: 1 item per cycle, each
// stage advancing whenever the stage after it is empty or draining.
// Reset (synchronous, active low) clears the three stage valid bits only.
// Depends on aru_pkg, aru_if, aru_sub_stage and aru_mix_stage.
module aes_round_unit import aru_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  aru_in_if.sink    in_if,
  aru_out_if.source out_if
);

  aru_req_t req;
  logic     sub_valid;
  logic     sub_ready;
  aru_sub_t sub_data;
  logic     mix_valid;
  logic     mix_ready;
  aru_mix_t mix_data;
  logic     out_valid_r;
  aru_blk_t out_data_r;
  aru_blk_t out_data_nxt;

  assign req.mode  = aru_mode_t'(in_if.mode);
  assign req.state = {in_if.state_hi, in_if.state_lo};
  assign req.key   = {in_if.key_hi, in_if.key_lo};

  aru_sub_stage u_sub (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_if.valid),
    .up_ready (in_if.ready),
    .up_data  (req),
    .dn_valid (sub_valid),
    .dn_ready (sub_ready),
    .dn_data  (sub_data)
  );

  aru_mix_stage u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sub_valid),
    .up_ready (sub_ready),
    .up_data  (sub_data),
    .dn_valid (mix_valid),
    .dn_ready (mix_ready),
    .dn_data  (mix_data)
  );

  assign out_data_nxt = mix_data.data ^ mix_data.key;
  assign mix_ready    = !out_valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mix_ready) begin
      out_valid_r <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mix_ready && mix_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.result_lo = out_data_r[7:0];
  assign out_if.result_hi = out_data_r[15:8];

`ifndef ASSERT_OFF
  a_empty_tail_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled while result register is empty");

  a_sub_hold: assert property (@(posedge clk) disable iff (!rst_n)
    sub_valid && !sub_ready |=> sub_valid && $stable(sub_data))
    else $error("substitution stage lost or changed a stalled item");

  a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
    mix_valid && !mix_ready |=> mix_valid && $stable(mix_data))
    else $error("mix stage lost or changed a stalled item");
`endif

endmodule

/* rtl/aru_sub_stage.sv */
// First pipeline stage: (inverse) ShiftRows and (inverse) SubBytes, registered.
// Depends on aru_pkg for the S-box tables and stage payload types.
module aru_sub_stage import aru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  aru_req_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output aru_sub_t dn_data
);

  logic     valid_r;
  aru_sub_t data_r;
  aru_sub_t data_nxt;
  logic     dec;

  assign dec = (up_data.mode == MODE_DEC) || (up_data.mode == MODE_DEC_LAST);

  always_comb begin
    logic [1:0] sc;
    logic [7:0] v;
    data_nxt.dec  = dec;
    data_nxt.last = (up_data.mode == MODE_ENC_LAST) || (up_data.mode == MODE_DEC_LAST);
    data_nxt.key  = up_data.key;
    data_nxt.data = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sc = dec ? 2'(c - r) : 2'(c + r);
        v  = up_data.state[{sc, 2'(r)}];
        data_nxt.data[4 * c + r] = dec ? DEC_SBOX[v] : FWD_SBOX[v];
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* rtl/aru_mix_stage.sv */
// Second pipeline stage: MixColumns or InvMixColumns, bypassed on last rounds.
// Depends on aru_pkg for the GF(2^8) column function and payload types.
module aru_mix_stage import aru_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  aru_sub_t up_data,
  output logic     dn_valid,
  input  logic     dn_ready,
  output aru_mix_t dn_data
);

  logic     valid_r;
  aru_mix_t data_r;
  aru_mix_t data_nxt;

  always_comb begin
    data_nxt.key  = up_data.key;
    data_nxt.data = up_data.data;
    if (!up_data.last) begin
      for (int c = 0; c < 4; c++) begin
        data_nxt.data[4 * c +: 4] = mix_col(up_data.data[4 * c +: 4], up_data.dec);
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

/* bench/tb_aes_round_unit.sv */
// Testbench for aes_round_unit: directed and random AES rounds in all four modes,
// checked against a bench-side round predictor with S-boxes built from GF(2^8) math.
// Depends on aru_pkg and the aru_in_if / aru_out_if channel interfaces.
module tb_aes_round_unit import aru_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } round_out_t;

  localparam int FWD_MIX_K [4] = '{2, 3, 1, 1};
  localparam int INV_MIX_K [4] = '{14, 11, 13, 9};

  logic clk;
  logic rst_n;

  aru_in_if  in_bus ();
  aru_out_if out_bus ();

  aes_round_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_bus),
    .out_if (out_bus)
  );

  logic [7:0] sub_box [256];
  logic [7:0] inv_sub_box [256];
  round_out_t expected_rounds [$];
  int         mismatches = 0;
  bit         send_idle = 1'b1;
  bit         recv_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input int k);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = a;
    for (int b = 0; b < 8; b++) begin
      if (k[b]) acc ^= p;
      p = gf_xtime(p);
    end
    return acc;
  endfunction

  function automatic void build_sub_boxes();
    logic [7:0] recip;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      recip = 8'h00;
      for (int y = 1; y < 256; y++) begin
        if (x != 0 && gf_mul(8'(x), y) == 8'h01) recip = 8'(y);
      end
      s = recip ^ {recip[6:0], recip[7]} ^ {recip[5:0], recip[7:6]} ^
          {recip[4:0], recip[7:5]} ^ {recip[3:0], recip[7:4]} ^ 8'h63;
      sub_box[x]     = s;
      inv_sub_box[s] = 8'(x);
    end
  endfunction

  function automatic round_out_t predict_round(input logic [1:0] mode,
                                               input logic [63:0] st_lo,
                                               input logic [63:0] st_hi,
                                               input logic [63:0] k_lo,
                                               input logic [63:0] k_hi);
    logic [15:0][7:0] st;
    logic [15:0][7:0] rk;
    logic [15:0][7:0] t;
    logic [3:0][7:0]  col;
    logic [7:0]       acc;
    logic             dec;
    logic             last;
    int               src;
    round_out_t       res;
    st   = {st_hi, st_lo};
    rk   = {k_hi, k_lo};
    dec  = mode[1];
    last = mode[0];
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = dec ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[r + 4 * c] = dec ? inv_sub_box[st[r + 4 * src]] : sub_box[st[r + 4 * src]];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        for (int j = 0; j < 4; j++) col[j] = t[4 * c + j];
        for (int r = 0; r < 4; r++) begin
          acc = 8'h00;
          for (int j = 0; j < 4; j++) begin
            acc ^= gf_mul(col[(r + j) % 4], dec ? INV_MIX_K[j] : FWD_MIX_K[j]);
          end
          t[4 * c + r] = acc;
        end
      end
    end
    t = t ^ rk;
    res.lo = t[7:0];
    res.hi = t[15:8];
    return res;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_round(input aru_mode_t mode, input logic [63:0] st_lo,
                            input logic [63:0] st_hi, input logic [63:0] k_lo,
                            input logic [63:0] k_hi);
    int gap;
    gap = send_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.mode     <= mode;
    in_bus.state_lo <= st_lo;
    in_bus.state_hi <= st_hi;
    in_bus.key_lo   <= k_lo;
    in_bus.key_hi   <= k_hi;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    expected_rounds.push_back(predict_round(mode, st_lo, st_hi, k_lo, k_hi));
  endtask

  task automatic test_directed();
    aru_mode_t m;
    for (int i = 0; i < 4; i++) begin
      m = aru_mode_t'(i);
      send_round(m, '0, '0, '0, '0);
      send_round(m, '1, '1, '1, '1);
      send_round(m, {8{8'h55}}, {8{8'h55}}, {8{8'hAA}}, {8{8'hAA}});
      send_round(m, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, '0, '1);
      send_round(m, 64'h2be2f4a0bee33d19, 64'h0848f8e92a8dc69a,
                 64'hb12c548817fefaa0, 64'h05766c2a3939a323);
    end
  endtask

  task automatic test_back_to_back();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    for (int i = 0; i < 200; i++) begin
      send_round(aru_mode_t'($urandom_range(0, 3)), rand64(), rand64(), rand64(), rand64());
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  task automatic test_random_rounds();
    logic [63:0] st_lo;
    logic [63:0] st_hi;
    logic [7:0]  fill;
    for (int i = 0; i < 1050; i++) begin
      send_idle = (i % 150) >= 20;
      recv_idle = (i % 150) >= 10;
      st_lo = rand64();
      st_hi = rand64();
      if ($urandom_range(0, 7) == 0) begin
        fill  = 8'($urandom);
        st_lo = {8{fill}};
        st_hi = {8{fill}};
      end
      send_round(aru_mode_t'($urandom_range(0, 3)), st_lo, st_hi, rand64(), rand64());
    end
    send_idle = 1'b1;
    recv_idle = 1'b1;
  endtask

  initial begin
    int gap;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = recv_idle ? $urandom_range(0, 13) : 0;
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    round_out_t exp_res;
    if (rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      if (expected_rounds.size() == 0) begin
        $error("unexpected result: result_lo %h result_hi %h",
               out_bus.result_lo, out_bus.result_hi);
        mismatches++;
      end else begin
        exp_res = expected_rounds.pop_front();
        if (out_bus.result_lo !== exp_res.lo) begin
          $error("result_lo mismatch: expected %h, actual %h", exp_res.lo, out_bus.result_lo);
          mismatches++;
        end
        if (out_bus.result_hi !== exp_res.hi) begin
          $error("result_hi mismatch: expected %h, actual %h", exp_res.hi, out_bus.result_hi);
          mismatches++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.mode     <= '0;
    in_bus.state_lo <= '0;
    in_bus.state_hi <= '0;
    in_bus.key_lo   <= '0;
    in_bus.key_hi   <= '0;
    build_sub_boxes();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_back_to_back();
    test_random_rounds();
    in_bus.valid <= 1'b0;
    wait (expected_rounds.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_rounds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/aru_pkg.sv
rtl/aru_if.sv
rtl/aru_sub_stage.sv
rtl/aru_mix_stage.sv
rtl/aes_round_unit.sv
bench/tb_aes_round_unit.sv
